FILE: hw/rtl/pes_pkg.sv
`timescale 1ns / 1ps

package pes_pkg;

   localparam int MAX_QUERIES_DEF = 64;

   localparam int ID_W   = 16;
   localparam int PER_W  = 12;
   localparam int TIME_W = 32;
   localparam int STAT_W = 2;

   // request mode
   localparam logic MODE_REGISTER = 1'b0;
   localparam logic MODE_FETCH    = 1'b1;

   // response status codes
   localparam logic [STAT_W-1:0] STATUS_REGISTERED = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_EVENT      = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL       = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_EMPTY      = 2'd3;

   // one table entry as held in RAM
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PER_W-1:0]  period;
      logic [TIME_W-1:0] due;
   } entry_type;

endpackage

FILE: hw/rtl/pes_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, registered read.
module pes_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                    wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                    rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: hw/rtl/periodic_event_scheduler_unit.sv
`timescale 1ns / 1ps
// Sequence: a register request goes through S_REG to S_EMIT, a fetch from an empty table goes
//   straight to S_EMIT; any other fetch scans all N stored entries, then S_UPDATE and S_EMIT.
// Throughput: one request at a time; fetch cost is set by the RAM scan, one entry per cycle
//   through one comparator.
// Reset (synchronous, active high) empties the table and drops any pending response;
//   RAM contents are left as they are and never read before being written.
module periodic_event_scheduler_unit #(
   parameter int MAX_QUERIES = pes_pkg::MAX_QUERIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_mode,
   input  logic [pes_pkg::ID_W-1:0]    req_query_id,
   input  logic [pes_pkg::PER_W-1:0]   req_query_period,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [pes_pkg::STAT_W-1:0]  rsp_status,
   output logic [pes_pkg::ID_W-1:0]    rsp_event_id,
   output logic [pes_pkg::TIME_W-1:0]  rsp_event_time
);

   // address width covers the table, count width holds the table size itself
   localparam int AW   = (MAX_QUERIES > 1) ? $clog2(MAX_QUERIES) : 1;
   localparam int CW   = $clog2(MAX_QUERIES + 1);
   localparam int SUMW = pes_pkg::TIME_W + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REG,
      S_SCAN,
      S_UPDATE,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;

   // control
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic          data_vld_ff, data_vld_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload
   logic [AW-1:0]                 data_idx_ff, data_idx_in;
   logic [pes_pkg::ID_W-1:0]      qid_ff, qid_in;
   logic [pes_pkg::PER_W-1:0]     qper_ff, qper_in;
   pes_pkg::entry_type            best_ff, best_in;
   logic [AW-1:0]                 best_idx_ff, best_idx_in;
   logic [pes_pkg::STAT_W-1:0]    pend_status_ff, pend_status_in;
   logic [pes_pkg::ID_W-1:0]      pend_id_ff, pend_id_in;
   logic [pes_pkg::TIME_W-1:0]    pend_time_ff, pend_time_in;
   logic [pes_pkg::STAT_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [pes_pkg::ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic [pes_pkg::TIME_W-1:0]    rsp_time_ff, rsp_time_in;

   // RAM port signals
   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   pes_pkg::entry_type    ram_wr_data;
   pes_pkg::entry_type    ram_rd_data;

   logic                  table_full;
   logic [CW-1:0]         count_m1;
   logic                  take;
   logic [SUMW-1:0]       due_sum;
   logic [pes_pkg::TIME_W-1:0] due_next;

   pes_ram #(
      .WIDTH ($bits(pes_pkg::entry_type)),
      .DEPTH (MAX_QUERIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign table_full = (count_ff == CW'(MAX_QUERIES));
   assign count_m1   = count_ff - CW'(1);

   // strict less-than keeps the lowest slot on a full tie
   assign take = (data_idx_ff == '0) ||
                 (ram_rd_data.due < best_ff.due) ||
                 ((ram_rd_data.due == best_ff.due) && (ram_rd_data.id < best_ff.id));

   // saturating advance of the chosen due time
   assign due_sum  = {1'b0, best_ff.due} + SUMW'(best_ff.period);
   assign due_next = due_sum[SUMW-1] ? {pes_pkg::TIME_W{1'b1}}
                                     : due_sum[pes_pkg::TIME_W-1:0];

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      issue_in       = issue_ff;
      data_vld_in    = 1'b0;
      data_idx_in    = data_idx_ff;
      qid_in         = qid_ff;
      qper_in        = qper_ff;
      best_in        = best_ff;
      best_idx_in    = best_idx_ff;
      pend_status_in = pend_status_ff;
      pend_id_in     = pend_id_ff;
      pend_time_in   = pend_time_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_time_in    = rsp_time_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = count_ff[AW-1:0];
      ram_wr_data    = '{id: qid_ff, period: qper_ff, due: pes_pkg::TIME_W'(qper_ff)};

      // response slot drains independently of the sequencer
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               qid_in  = req_query_id;
               qper_in = req_query_period;
               if (req_mode == pes_pkg::MODE_REGISTER) begin
                  state_in = S_REG;
               end else if (count_ff == '0) begin
                  pend_status_in = pes_pkg::STATUS_EMPTY;
                  pend_id_in     = '0;
                  pend_time_in   = '0;
                  state_in       = S_EMIT;
               end else begin
                  issue_in = '0;
                  state_in = S_SCAN;
               end
            end
         end

         S_REG: begin
            pend_id_in   = '0;
            pend_time_in = '0;
            if (table_full) begin
               pend_status_in = pes_pkg::STATUS_FULL;
            end else begin
               ram_wr_en      = 1'b1;
               count_in       = count_ff + CW'(1);
               pend_status_in = pes_pkg::STATUS_REGISTERED;
            end
            state_in = S_EMIT;
         end

         S_SCAN: begin
            // one read issued per cycle, compared the cycle after
            if (issue_ff < count_ff) begin
               issue_in    = issue_ff + CW'(1);
               data_vld_in = 1'b1;
               data_idx_in = issue_ff[AW-1:0];
            end
            if (data_vld_ff) begin
               if (take) begin
                  best_in     = ram_rd_data;
                  best_idx_in = data_idx_ff;
               end
               if (data_idx_ff == count_m1[AW-1:0]) begin
                  data_vld_in = 1'b0;
                  state_in    = S_UPDATE;
               end
            end
         end

         S_UPDATE: begin
            ram_wr_en      = 1'b1;
            ram_wr_addr    = best_idx_ff;
            ram_wr_data    = '{id: best_ff.id, period: best_ff.period, due: due_next};
            pend_status_in = pes_pkg::STATUS_EVENT;
            pend_id_in     = best_ff.id;
            pend_time_in   = best_ff.due;
            state_in       = S_EMIT;
         end

         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_id_in     = pend_id_ff;
               rsp_time_in   = pend_time_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      data_idx_ff    <= data_idx_in;
      qid_ff         <= qid_in;
      qper_ff        <= qper_in;
      best_ff        <= best_in;
      best_idx_ff    <= best_idx_in;
      pend_status_ff <= pend_status_in;
      pend_id_ff     <= pend_id_in;
      pend_time_ff   <= pend_time_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_time_ff    <= rsp_time_in;
   end

   // only idle takes a new request; the response register sits apart
   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_event_id   = rsp_id_ff;
   assign rsp_event_time = rsp_time_ff;

   // an accepted request holds off the next one
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while a previous one is in progress");

   // a successful registration bumps the entry count by one
   a_count_step : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REG && !table_full) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("entry count not advanced on registration");

   // the table never overfills
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REG && table_full) |=> (count_ff == CW'(MAX_QUERIES)))
      else $error("entry count changed on register into a full table");

   // an event response needs a non-empty table
   a_event_nonempty : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (count_ff != '0))
      else $error("scan started over an empty table");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

// Scheduler testbench.
// A scoreboard object keeps its own copy of the query table. Each accepted request is
// noted there, and the response that the request should give is queued. Responses are
// popped in order and compared field by field. Stimulus runs in two parts. The directed
// part covers the empty table, the extreme ids and periods, and ties. The random part
// fills the table in its first quarter and then keeps fetching against a full table.
module testbench;

   localparam int ID_W   = pes_pkg::ID_W;
   localparam int PER_W  = pes_pkg::PER_W;
   localparam int TIME_W = pes_pkg::TIME_W;
   localparam int STAT_W = pes_pkg::STAT_W;

   localparam int TABLE_DEPTH     = pes_pkg::MAX_QUERIES_DEF;
   localparam int RANDOM_REQUESTS = 1030;
   localparam int PHASE_LEN       = 260;
   // settle time before calling the run done
   localparam int SETTLE_CYCLES   = TABLE_DEPTH + 16;
   // watchdog limit, well over the length of a slow run
   localparam int CYCLE_LIMIT     = 1_000_000;

   // Scoreboard: mirrors the table and holds the responses still owed by the block.
   class sched_scoreboard;
      typedef struct packed {
         logic [STAT_W-1:0] status;
         logic [ID_W-1:0]   id;
         logic [TIME_W-1:0] due;
      } response_type;

      logic [ID_W-1:0]   ids       [TABLE_DEPTH];
      logic [PER_W-1:0]  periods   [TABLE_DEPTH];
      logic [TIME_W-1:0] due_times [TABLE_DEPTH];
      int unsigned       stored;
      response_type      awaited [$];
      int unsigned       failures;

      function new();
         stored   = 0;
         failures = 0;
      endfunction

      function void note_request(logic mode, logic [ID_W-1:0] qid, logic [PER_W-1:0] qper);
         response_type  r;
         int unsigned   best;
         logic [TIME_W:0] sum;
         r = '0;
         if (mode == pes_pkg::MODE_REGISTER) begin
            if (stored >= TABLE_DEPTH) begin
               r.status = pes_pkg::STATUS_FULL;
            end else begin
               ids[stored]       = qid;
               periods[stored]   = qper;
               due_times[stored] = {{(TIME_W-PER_W){1'b0}}, qper};
               stored++;
               r.status = pes_pkg::STATUS_REGISTERED;
            end
         end else if (stored == 0) begin
            r.status = pes_pkg::STATUS_EMPTY;
         end else begin
            // earliest due time, then smaller id; lowest slot wins a full tie
            best = 0;
            for (int unsigned i = 1; i < stored; i++) begin
               if (due_times[i] < due_times[best] ||
                   (due_times[i] == due_times[best] && ids[i] < ids[best]))
                  best = i;
            end
            r.status = pes_pkg::STATUS_EVENT;
            r.id     = ids[best];
            r.due    = due_times[best];
            sum = {1'b0, due_times[best]} + {{(TIME_W+1-PER_W){1'b0}}, periods[best]};
            due_times[best] = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
         end
         awaited = {awaited, r};
      endfunction

      function void check_response(logic [STAT_W-1:0] status, logic [ID_W-1:0] id,
                                   logic [TIME_W-1:0] due);
         response_type want;
         if (awaited.size() == 0) begin
            $error("unexpected response: status %0d id %h time %h", status, id, due);
            failures++;
            return;
         end
         want = awaited.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            failures++;
         end
         if (id !== want.id) begin
            $error("event_id: expected %h, got %h", want.id, id);
            failures++;
         end
         if (due !== want.due) begin
            $error("event_time: expected %h, got %h", want.due, due);
            failures++;
         end
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction
   endclass

   // ---------------------------------------------------------------- clock, reset, DUT
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic              req_mode         = pes_pkg::MODE_REGISTER;
   logic [ID_W-1:0]   req_query_id     = '0;
   logic [PER_W-1:0]  req_query_period = '0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic [ID_W-1:0]   rsp_event_id;
   logic [TIME_W-1:0] rsp_event_time;

   initial forever #4 clock = ~clock;

   periodic_event_scheduler_unit #(
      .MAX_QUERIES(TABLE_DEPTH)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_query_id    (req_query_id),
      .req_query_period(req_query_period),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_event_id    (rsp_event_id),
      .rsp_event_time  (rsp_event_time)
   );

   sched_scoreboard board;

   // cleared for one phase so that requests and responses run back to back
   bit idling = 1'b1;

   // Idle length: mostly none or short, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (!idling)   return 0;
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------- response side
   // Stall is held for a random spell, then redrawn. It ignores rsp_valid, so it can
   // land on any cycle of a fetch scan as well as on the response itself.
   int unsigned stall_hold = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_hold != 0) begin
         stall_hold = stall_hold - 1;
      end else begin
         rsp_stall <= idling && ($urandom_range(0, 2) == 0);
         stall_hold = pick_gap();
      end
   end

   // Responses are taken at the edge where valid is high and stall is low.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_status, rsp_event_id, rsp_event_time);
   end

   // Watchdog: a hung handshake ends the run here.
   int unsigned cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------- request side
   // Called at a clock edge. Valid stays high after acceptance, so a request that
   // follows with no gap goes straight out. A gap or a wait for responses lowers it.
   task automatic send_request(logic mode, logic [ID_W-1:0] qid, logic [PER_W-1:0] qper);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_query_id     <= qid;
      req_query_period <= qper;
      do @(posedge clock); while (req_stall);
      board.note_request(mode, qid, qper);
   endtask

   // Sender goes quiet until every owed response has come back. The extra edge keeps
   // the lowering of valid apart from any raise by the next request.
   task automatic wait_for_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- stimulus
   initial begin
      int unsigned     reg_odds;
      int unsigned     roll;
      logic            mode;
      logic [ID_W-1:0] qid;
      logic [PER_W-1:0] qper;

      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: fetches from an empty table first
      send_request(pes_pkg::MODE_FETCH, 16'h0000, 12'h000);
      send_request(pes_pkg::MODE_FETCH, 16'hFFFF, 12'hFFF);
      // extremes of id and period; one entry, fetched twice
      send_request(pes_pkg::MODE_REGISTER, 16'hFFFF, 12'hFFF);
      send_request(pes_pkg::MODE_FETCH, 16'h0000, 12'h000);
      send_request(pes_pkg::MODE_FETCH, 16'h0000, 12'h000);
      // full tie: same id and period twice; lower slot must go first
      send_request(pes_pkg::MODE_REGISTER, 16'h0000, 12'h001);
      send_request(pes_pkg::MODE_REGISTER, 16'h0000, 12'h001);
      // same due time, larger id loses
      send_request(pes_pkg::MODE_REGISTER, 16'hA5A5, 12'h001);
      send_request(pes_pkg::MODE_REGISTER, 16'h5A5A, 12'h800);
      send_request(pes_pkg::MODE_REGISTER, 16'h0003, 12'h555);
      send_request(pes_pkg::MODE_REGISTER, 16'hC000, 12'hAAA);
      repeat (12) send_request(pes_pkg::MODE_FETCH, 16'h0000, 12'h000);
      wait_for_responses();

      // random: about a quarter registers until the table is full, then few
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n != 0 && n % PHASE_LEN == 0) begin
            wait_for_responses();
            idling = (n != PHASE_LEN);
         end
         reg_odds = (board.stored < TABLE_DEPTH) ? 25 : 8;
         mode = ($urandom_range(0, 99) < reg_odds) ? pes_pkg::MODE_REGISTER
                                                   : pes_pkg::MODE_FETCH;
         // narrow ids and short periods make ties common
         roll = $urandom_range(0, 99);
         if (roll < 50)      qid = ID_W'($urandom_range(0, 7));
         else if (roll < 80) qid = ID_W'($urandom_range(0, 255));
         else                qid = ID_W'($urandom_range(0, 16'hFFFF));
         roll = $urandom_range(0, 99);
         if (roll < 40)      qper = PER_W'($urandom_range(1, 8));
         else if (roll < 70) qper = PER_W'($urandom_range(1, 64));
         else                qper = PER_W'($urandom_range(1, 12'hFFF));
         send_request(mode, qid, qper);
      end

      wait_for_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
